>>> rtl/lxr_pkg.sv
`timescale 1ns / 1ps
package lxr_pkg;

  // Token kinds
  localparam logic [2:0] KIND_END      = 3'd0;
  localparam logic [2:0] KIND_COMMENT  = 3'd1;
  localparam logic [2:0] KIND_LABEL    = 3'd2;
  localparam logic [2:0] KIND_SYMBOL   = 3'd3;
  localparam logic [2:0] KIND_REGISTER = 3'd4;
  localparam logic [2:0] KIND_IO       = 3'd5;
  localparam logic [2:0] KIND_NUMBER   = 3'd6;
  localparam logic [2:0] KIND_INVALID  = 3'd7;

  // Most tokens one character can produce
  localparam int SLOTS = 3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       final_char;
  } char_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [2:0]  name_index;
    logic        line_ok;
    logic        last_token;
  } token_t;

  // Tokens caused by one character, slot 0 oldest
  typedef struct packed {
    token_t [SLOTS-1:0] tok;
    logic [1:0]         count;
  } bundle_t;

endpackage

>>> rtl/assembly_line_lexer_core.sv
`timescale 1ns / 1ps
// Channel  | Handshake        | Payload                 | Beat taken when
// ---------+------------------+-------------------------+-----------------
// input    | push / full      | item  (char_item_t)     | push && !full
// result   | pop / empty      | token (token_t)         | pop && !empty
//
// One character per cycle while full is low; the scanner state updates in the
// accepting cycle. A character yields zero to three tokens, queued as one
// bundle; the first shows on token once it heads the queue, then one token
// per cycle while popped. full rises only when the four-bundle queue is full;
// result stalls never reach the scanner otherwise. Reset (rst, synchronous)
// empties the queue and puts the scanner at position zero, between tokens.
module assembly_line_lexer_core #(
  parameter int POSITION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  lxr_pkg::char_item_t item,
  output logic                empty,
  input  logic                pop,
  output lxr_pkg::token_t     token
);
  import lxr_pkg::*;

  logic    accept;
  logic    enq;
  logic    deq;
  logic    q_empty;
  bundle_t bundle;
  bundle_t head;

  assign accept = push && !full;

  // Front: scans characters and classifies tokens
  lxr_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (item),
    .enq   (enq),
    .bundle(bundle)
  );

  // Decoupling queue of token bundles
  lxr_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .enq  (enq),
    .wdata(bundle),
    .deq  (deq),
    .head (head),
    .empty(q_empty),
    .full (full)
  );

  // Back: hands out tokens of the head bundle one beat at a time
  lxr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_empty(q_empty),
    .pop    (pop),
    .deq    (deq),
    .empty  (empty),
    .token  (token)
  );

endmodule

>>> rtl/lxr_front.sv
`timescale 1ns / 1ps
module lxr_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  lxr_pkg::char_item_t item,
  output logic                enq,
  output lxr_pkg::bundle_t    bundle
);
  import lxr_pkg::*;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_LABEL   = 3'd2;
  localparam logic [2:0] MODE_SYMBOL  = 3'd3;
  localparam logic [2:0] MODE_NUMBER  = 3'd4;

  localparam int PW = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic [2:0]               mode;
  logic [POSITION_BITS-1:0] position;
  logic [15:0]              cur_start;
  logic [15:0]              cur_length;
  logic [7:0]               c0, c1;
  logic                     seen_invalid;

  logic [2:0]               mode_next;
  logic [POSITION_BITS-1:0] position_next;
  logic [15:0]              cur_start_next;
  logic [15:0]              cur_length_next;
  logic [7:0]               c0_next, c1_next;
  logic                     seen_invalid_next;
  bundle_t                  bnd;

  function automatic logic [15:0] sat16(input logic [POSITION_BITS-1:0] v);
    logic [PW-1:0] w;
    w = PW'(v);
    return (w > PW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [15:0] grow(input logic [15:0] len);
    return (len == 16'hFFFF) ? len : len + 16'd1;
  endfunction

  // Token for the open label, symbol or number
  function automatic token_t close_tok(input logic [2:0] m, input logic has_next,
                                       input logic [7:0] c, input logic [15:0] st,
                                       input logic [15:0] len, input logic [7:0] a,
                                       input logic [7:0] b);
    token_t t;
    t = '0;
    t.token_start  = st;
    t.token_length = len;
    t.token_kind   = KIND_INVALID;
    if (m == MODE_LABEL) begin
      t.token_kind = (has_next && c == CH_SPACE) ? KIND_INVALID : KIND_LABEL;
    end else if (m == MODE_NUMBER) begin
      t.token_kind = (has_next && c != CH_SPACE) ? KIND_INVALID : KIND_NUMBER;
    end else begin
      t.token_kind = KIND_SYMBOL;
      if (len == 16'd2) begin
        t.token_kind = KIND_REGISTER;
        unique case ({a, b})
          "M0":    t.name_index = 3'd0;
          "M1":    t.name_index = 3'd1;
          "PC":    t.name_index = 3'd2;
          "RX":    t.name_index = 3'd3;
          "N1":    t.name_index = 3'd4;
          "N2":    t.name_index = 3'd5;
          "N3":    t.name_index = 3'd6;
          default: t.token_kind = KIND_SYMBOL;
        endcase
      end else if (len == 16'd1 && a >= 8'h41 && a <= 8'h46) begin
        t.token_kind = KIND_IO;
        t.name_index = 3'(a - 8'h41);
      end
    end
    return t;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       open_tok;
    token_t     t;
    c                 = item.char_byte;
    mode_next         = mode;
    cur_start_next    = cur_start;
    cur_length_next   = cur_length;
    c0_next           = c0;
    c1_next           = c1;
    seen_invalid_next = seen_invalid;
    bnd               = '0;
    t                 = '0;
    open_tok          = 1'b0;

    if (mode == MODE_COMMENT) begin
      if (c == CH_NL) mode_next = MODE_IDLE;
    end else begin
      if (mode == MODE_LABEL || mode == MODE_SYMBOL) begin
        if (is_digit(c) || is_alpha(c)) begin
          if (mode == MODE_SYMBOL && cur_length == 16'd1) c1_next = c;
          cur_length_next = grow(cur_length);
        end else begin
          open_tok = 1'b1;
        end
      end else if (mode == MODE_NUMBER) begin
        if (is_digit(c)) cur_length_next = grow(cur_length);
        else open_tok = 1'b1;
      end
      if (open_tok) begin
        t = close_tok(mode, 1'b1, c, cur_start, cur_length, c0, c1);
        if (t.token_kind == KIND_INVALID) seen_invalid_next = 1'b1;
        bnd.tok[bnd.count] = t;
        bnd.count          = bnd.count + 2'd1;
        mode_next          = MODE_IDLE;
      end
      if (mode_next == MODE_IDLE && !is_space(c)) begin
        cur_start_next = sat16(position);
        if (c == CH_HASH) begin
          t              = '0;
          t.token_kind   = KIND_COMMENT;
          t.token_start  = sat16(position);
          t.token_length = 16'd1;
          bnd.tok[bnd.count] = t;
          bnd.count          = bnd.count + 2'd1;
          mode_next          = MODE_COMMENT;
        end else if (c == CH_DOT) begin
          mode_next       = MODE_LABEL;
          cur_length_next = 16'd0;
        end else if (is_alpha(c)) begin
          mode_next       = MODE_SYMBOL;
          cur_length_next = 16'd1;
          c0_next         = c;
          c1_next         = 8'd0;
        end else if (is_digit(c)) begin
          mode_next       = MODE_NUMBER;
          cur_length_next = 16'd1;
        end else begin
          t              = '0;
          t.token_kind   = KIND_INVALID;
          t.token_start  = sat16(position);
          t.token_length = 16'd1;
          bnd.tok[bnd.count] = t;
          bnd.count          = bnd.count + 2'd1;
          seen_invalid_next  = 1'b1;
        end
      end
    end

    position_next = (position == POS_MAX) ? position : position + 1'b1;

    if (item.final_char) begin
      if (mode_next == MODE_LABEL || mode_next == MODE_SYMBOL ||
          mode_next == MODE_NUMBER) begin
        t = close_tok(mode_next, 1'b0, c, cur_start_next, cur_length_next,
                      c0_next, c1_next);
        if (t.token_kind == KIND_INVALID) seen_invalid_next = 1'b1;
        bnd.tok[bnd.count] = t;
        bnd.count          = bnd.count + 2'd1;
      end
      t             = '0;
      t.token_kind  = KIND_END;
      t.token_start = sat16(position_next);
      t.line_ok     = !seen_invalid_next;
      t.last_token  = 1'b1;
      bnd.tok[bnd.count] = t;
      bnd.count          = bnd.count + 2'd1;
      // line done: back to reset state
      mode_next         = MODE_IDLE;
      position_next     = '0;
      cur_start_next    = '0;
      cur_length_next   = '0;
      c0_next           = '0;
      c1_next           = '0;
      seen_invalid_next = 1'b0;
    end
  end

  assign bundle = bnd;
  assign enq    = accept && (bnd.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      position     <= '0;
      cur_start    <= '0;
      cur_length   <= '0;
      c0           <= '0;
      c1           <= '0;
      seen_invalid <= 1'b0;
    end else if (accept) begin
      mode         <= mode_next;
      position     <= position_next;
      cur_start    <= cur_start_next;
      cur_length   <= cur_length_next;
      c0           <= c0_next;
      c1           <= c1_next;
      seen_invalid <= seen_invalid_next;
    end
  end

endmodule

>>> rtl/lxr_fifo.sv
`timescale 1ns / 1ps
module lxr_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             enq,
  input  lxr_pkg::bundle_t wdata,
  input  logic             deq,
  output lxr_pkg::bundle_t head,
  output logic             empty,
  output logic             full
);
  import lxr_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  bundle_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   fill;

  assign empty = (fill == '0);
  assign full  = (fill == (AW+1)'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (enq) wr_ptr <= wr_ptr + 1'b1;
      if (deq) rd_ptr <= rd_ptr + 1'b1;
      if (enq && !deq) fill <= fill + 1'b1;
      else if (deq && !enq) fill <= fill - 1'b1;
    end
  end

endmodule

>>> rtl/lxr_back.sv
`timescale 1ns / 1ps
module lxr_back (
  input  logic             clk,
  input  logic             rst,
  input  lxr_pkg::bundle_t head,
  input  logic             q_empty,
  input  logic             pop,
  output logic             deq,
  output logic             empty,
  output lxr_pkg::token_t  token
);
  import lxr_pkg::*;

  logic [1:0] slot;
  logic       beat;

  assign empty = q_empty;
  assign token = head.tok[slot];
  assign beat  = pop && !q_empty;
  // last slot of the head bundle retires it
  assign deq   = beat && (slot == head.count - 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (deq) begin
      slot <= '0;
    end else if (beat) begin
      slot <= slot + 2'd1;
    end
  end

endmodule

>>> dv/assembly_line_lexer_core_tb.sv
`timescale 1ns / 1ps
module assembly_line_lexer_core_tb;
  import lxr_pkg::*;

  localparam int POSITION_BITS = 16;
  localparam longint unsigned POS_MAX = (64'd1 << POSITION_BITS) - 1;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the bundle queue
  localparam int DRAIN_CYCLES = 16;   // settle time after the last token
  localparam int LONG_LABEL = 40;     // label body length for the unthrottled phase

  // Characters the scanner treats specially
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Scanner state of the predictor
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_COMMENT, SCAN_LABEL, SCAN_SYMBOL, SCAN_NUMBER
  } scan_e;

  // Predicts the tokens each accepted character yields and checks them in order.
  class token_scoreboard;
    token_t      expected_q[$];
    int          errors;
    scan_e       mode;
    longint unsigned pos;
    logic [15:0] tok_start;
    int unsigned tok_len;
    logic [7:0]  c0, c1;      // first two characters of an open symbol
    bit          bad_seen;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = SCAN_IDLE;
      pos = 0;
      tok_start = '0;
      tok_len = 0;
      c0 = '0;
      c1 = '0;
      bad_seen = 1'b0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function logic [15:0] sat16(longint unsigned v);
      return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function void emit(logic [2:0] kind, longint unsigned start, int unsigned len,
                       logic [2:0] idx, bit ok, bit last);
      token_t t;
      t.token_kind   = kind;
      t.token_start  = sat16(start);
      t.token_length = len[15:0];
      t.name_index   = idx;
      t.line_ok      = ok;
      t.last_token   = last;
      expected_q = {expected_q, t};
    endfunction

    // Close an open label/symbol/number; has_next means c follows it on the line.
    function void close_open(bit has_next, logic [7:0] c);
      logic [2:0] kind;
      logic [2:0] idx;
      idx = '0;
      case (mode)
        SCAN_LABEL:  kind = (has_next && c == CH_SPACE) ? KIND_INVALID : KIND_LABEL;
        SCAN_NUMBER: kind = (has_next && c != CH_SPACE) ? KIND_INVALID : KIND_NUMBER;
        SCAN_SYMBOL: begin
          kind = KIND_SYMBOL;
          if (tok_len == 2) begin
            case ({c0, c1})
              "M0": begin kind = KIND_REGISTER; idx = 3'd0; end
              "M1": begin kind = KIND_REGISTER; idx = 3'd1; end
              "PC": begin kind = KIND_REGISTER; idx = 3'd2; end
              "RX": begin kind = KIND_REGISTER; idx = 3'd3; end
              "N1": begin kind = KIND_REGISTER; idx = 3'd4; end
              "N2": begin kind = KIND_REGISTER; idx = 3'd5; end
              "N3": begin kind = KIND_REGISTER; idx = 3'd6; end
              default: ;
            endcase
          end else if (tok_len == 1 && c0 >= "A" && c0 <= "F") begin
            kind = KIND_IO;
            idx = 3'(c0 - "A");
          end
        end
        default: return;
      endcase
      if (kind == KIND_INVALID) bad_seen = 1'b1;
      emit(kind, tok_start, tok_len, idx, 1'b0, 1'b0);
      mode = SCAN_IDLE;
    endfunction

    function void grow();
      if (tok_len < 16'hFFFF) tok_len++;
    endfunction

    // One accepted input beat: advance the scanner, queue what it emits.
    function void note_char(char_item_t beat);
      logic [7:0] c;
      longint unsigned p;
      c = beat.char_byte;
      p = pos;
      if (mode == SCAN_COMMENT) begin
        if (c == CH_NL) mode = SCAN_IDLE;
      end else begin
        if (mode == SCAN_LABEL || mode == SCAN_SYMBOL) begin
          if (is_digit(c) || is_alpha(c)) begin
            if (mode == SCAN_SYMBOL && tok_len == 1) c1 = c;
            grow();
          end else begin
            close_open(1'b1, c);
          end
        end else if (mode == SCAN_NUMBER) begin
          if (is_digit(c)) grow();
          else close_open(1'b1, c);
        end
        if (mode == SCAN_IDLE && !is_space(c)) begin
          tok_start = sat16(p);
          if (c == CH_HASH) begin
            emit(KIND_COMMENT, p, 1, 3'd0, 1'b0, 1'b0);
            mode = SCAN_COMMENT;
          end else if (c == CH_DOT) begin
            mode = SCAN_LABEL;
            tok_len = 0;
          end else if (is_alpha(c)) begin
            mode = SCAN_SYMBOL;
            tok_len = 1;
            c0 = c;
            c1 = '0;
          end else if (is_digit(c)) begin
            mode = SCAN_NUMBER;
            tok_len = 1;
          end else begin
            emit(KIND_INVALID, p, 1, 3'd0, 1'b0, 1'b0);
            bad_seen = 1'b1;
          end
        end
      end
      pos = (p >= POS_MAX) ? POS_MAX : p + 1;
      if (beat.final_char) begin
        if (mode != SCAN_COMMENT) close_open(1'b0, '0);
        emit(KIND_END, pos, 0, 3'd0, !bad_seen, 1'b1);
        clear();
      end
    endfunction

    task report(string what, int exp, int got);
      $display("MISMATCH at %0t: %0s expected %0d got %0d", $time, what, exp, got);
      errors++;
    endtask

    task check_token(token_t got);
      token_t exp;
      if (expected_q.size() == 0) begin
        report("token with nothing pending, kind", 0, got.token_kind);
        return;
      end
      exp = expected_q.pop_front();
      if (got.token_kind !== exp.token_kind)
        report("token_kind", exp.token_kind, got.token_kind);
      if (got.token_start !== exp.token_start)
        report("token_start", exp.token_start, got.token_start);
      if (got.token_length !== exp.token_length)
        report("token_length", exp.token_length, got.token_length);
      if (got.name_index !== exp.name_index)
        report("name_index", exp.name_index, got.name_index);
      if (got.line_ok !== exp.line_ok)
        report("line_ok", exp.line_ok, got.line_ok);
      if (got.last_token !== exp.last_token)
        report("last_token", exp.last_token, got.last_token);
    endtask
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  char_item_t item = '0;
  logic       empty;
  logic       pop = 1'b0;
  token_t     token;

  token_scoreboard sb = new();

  int unsigned send_idle_pct = 30;  // chance per cycle that the sender holds back
  int unsigned recv_idle_pct = 65;  // same for the receiver
  bit          hold_req = 1'b0;     // asks the receiver for one long hold-off
  int unsigned sent_chars = 0;
  int unsigned cycles = 0;
  logic [7:0]  line_buf[$];         // characters of the line being built

  assembly_line_lexer_core #(
    .POSITION_BITS(POSITION_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .token(token)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one input beat, with random gaps ahead of it; returns once it is taken.
  task automatic send_char(input logic [7:0] c, input bit fin);
    char_item_t beat;
    beat.char_byte = c;
    beat.final_char = fin;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= beat;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_char(beat);
    sent_chars++;
  endtask

  task automatic send_text(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], fin_last && i == s.len() - 1);
  endtask

  // Send line_buf, final flag on its last character
  task automatic send_buf();
    for (int i = 0; i < line_buf.size(); i++)
      send_char(line_buf[i], i == line_buf.size() - 1);
  endtask

  // Append one character to the line being built
  function automatic void put_char(input logic [7:0] c);
    line_buf = {line_buf, c};
  endfunction

  function automatic logic [7:0] rand_alpha();
    return $urandom_range(1) ? 8'("A" + $urandom_range(25)) : 8'("a" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return $urandom_range(2) == 0 ? 8'("0" + $urandom_range(9)) : rand_alpha();
  endfunction

  // Append one token-shaped piece plus an optional separator to line_buf.
  task automatic add_piece();
    string reg_names;
    string near_miss;
    int    i, n;
    reg_names = "M0M1PCRXN1N2N3";
    near_miss = "M2PXN0RCNM";
    case ($urandom_range(11))
      0, 1: begin  // register name
        i = $urandom_range(6);
        put_char(reg_names[2*i]);
        put_char(reg_names[2*i+1]);
      end
      2: begin     // two letters that look like a register but aren't
        i = $urandom_range(4);
        put_char(near_miss[2*i]);
        put_char(near_miss[2*i+1]);
      end
      3: put_char(8'("A" + $urandom_range(7)));  // io port or near it
      4: begin     // general symbol
        put_char(rand_alpha());
        n = $urandom_range(4);
        repeat (n) put_char(rand_alnum());
      end
      5, 6: begin  // label, possibly empty
        put_char(CH_DOT);
        n = $urandom_range(4);
        repeat (n) put_char(rand_alnum());
      end
      7, 8: begin  // number
        n = $urandom_range(1, 4);
        repeat (n) put_char(8'("0" + $urandom_range(9)));
      end
      9: begin     // comment, sometimes closed by newline
        put_char(CH_HASH);
        n = $urandom_range(4);
        repeat (n) put_char(8'($urandom_range(255)));
        if ($urandom_range(1)) put_char(CH_NL);
      end
      10: put_char(8'($urandom_range(255)));       // any byte at all
      default: put_char(8'($urandom_range(CH_TAB, CH_CR)));
    endcase
    i = $urandom_range(99);
    if (i < 60) put_char(CH_SPACE);
    else if (i < 75) put_char(8'($urandom_range(CH_TAB, CH_CR)));
  endtask

  // Mostly well-formed lines with random content; some pure noise.
  task automatic send_random_line();
    int n;
    line_buf.delete();
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 8);
      repeat (n) put_char(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) add_piece();
    end
    send_buf();
  endtask

  task automatic run_random(input int unsigned n_chars);
    int unsigned target;
    target = sent_chars + n_chars;
    while (sent_chars < target) send_random_line();
  endtask

  // Receiver: pops at random, or holds off for a long stretch on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_token(token);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed lines: every token kind and each terminator rule
    send_text("RX A 7", 1'b1);      // register, io port, number closed by line end
    send_text(".a:5z#", 1'b1);      // label closed by punctuation, number closed by letter,
                                    // comment open at line end: three tokens on one beat
    send_text(".x ", 1'b0);         // label closed by space is invalid
    send_char(8'hFF, 1'b1);         // top byte value: invalid
    send_char(8'h00, 1'b1);         // zero byte alone on a line
    send_text("#a\nN3", 1'b1);      // newline ends the comment
    send_text("\t", 1'b1);          // whitespace-only line: end token alone
    send_text("12 G", 1'b1);        // number closed by space stays valid; G is no io port

    // Sender mostly active, receiver mostly stalled; one long hold-off fills the queue
    run_random(90);
    hold_req = 1'b1;
    run_random(80);

    // Roles swapped
    send_idle_pct = 65;
    recv_idle_pct = 30;
    run_random(150);

    // No idling. A long label closed by a space is invalid; tokens follow on the line.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_char(CH_DOT, 1'b0);
    repeat (LONG_LABEL) send_char(rand_alnum(), 1'b0);
    send_text(" B7", 1'b1);
    run_random(130);
    push <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report("tokens never delivered", 0, sb.expected_q.size());

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lxr_pkg.sv
rtl/lxr_front.sv
rtl/lxr_fifo.sv
rtl/lxr_back.sv
rtl/assembly_line_lexer_core.sv
dv/assembly_line_lexer_core_tb.sv
